>>> rtl/class_file_stream_parser_defines.svh
// Assertion helpers for the class file parser.
`ifndef CLASS_FILE_STREAM_PARSER_DEFINES_SVH
`define CLASS_FILE_STREAM_PARSER_DEFINES_SVH

// Same-cycle implication on aclk, masked during reset.
`define CFSP_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("parser check failed");

// Next-cycle implication on aclk, masked during reset.
`define CFSP_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("parser check failed");

`endif

>>> rtl/cfsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cfsp_pkg;

    // Parse phases.
    localparam logic [4:0] PH_MAGIC   = 5'd0;
    localparam logic [4:0] PH_VERSION = 5'd1;
    localparam logic [4:0] PH_PCOUNT  = 5'd2;
    localparam logic [4:0] PH_CPTAG   = 5'd3;
    localparam logic [4:0] PH_CPA     = 5'd4;
    localparam logic [4:0] PH_CPB     = 5'd5;
    localparam logic [4:0] PH_UTF8    = 5'd6;
    localparam logic [4:0] PH_HEADER  = 5'd7;
    localparam logic [4:0] PH_ICOUNT  = 5'd8;
    localparam logic [4:0] PH_IENTRY  = 5'd9;
    localparam logic [4:0] PH_FBASE   = 5'd10;
    localparam logic [4:0] PH_MBASE   = 5'd14;
    localparam logic [4:0] PH_CBASE   = 5'd18;
    localparam logic [4:0] PH_DONE    = 5'd22;

    // Sub-phases of a member / attribute block.
    localparam logic [1:0] SUB_COUNT   = 2'd0;
    localparam logic [1:0] SUB_MEMBER  = 2'd1;
    localparam logic [1:0] SUB_ATTR    = 2'd2;
    localparam logic [1:0] SUB_PAYLOAD = 2'd3;

    // Sections.
    localparam logic [3:0] SEC_MAGIC    = 4'd0;
    localparam logic [3:0] SEC_VERSION  = 4'd1;
    localparam logic [3:0] SEC_POOL     = 4'd2;
    localparam logic [3:0] SEC_HEADER   = 4'd3;
    localparam logic [3:0] SEC_IFACE    = 4'd4;
    localparam logic [3:0] SEC_FIELDS   = 4'd5;
    localparam logic [3:0] SEC_METHODS  = 4'd6;
    localparam logic [3:0] SEC_CATTR    = 4'd7;
    localparam logic [3:0] SEC_FINISHED = 4'd8;

    // Part codes.
    localparam logic [3:0] PART_MAGIC     = 4'd0;
    localparam logic [3:0] PART_MINOR     = 4'd1;
    localparam logic [3:0] PART_MAJOR     = 4'd2;
    localparam logic [3:0] PART_COUNT     = 4'd3;
    localparam logic [3:0] PART_TAG       = 4'd4;
    localparam logic [3:0] PART_CONST_A   = 4'd5;
    localparam logic [3:0] PART_CONST_B   = 4'd6;
    localparam logic [3:0] PART_PAYLOAD   = 4'd7;
    localparam logic [3:0] PART_FLAGS     = 4'd8;
    localparam logic [3:0] PART_IFACE     = 4'd11;
    localparam logic [3:0] PART_ATTR_CNT  = 4'd12;
    localparam logic [3:0] PART_ATTR_NAME = 4'd13;
    localparam logic [3:0] PART_ATTR_LEN  = 4'd14;
    localparam logic [3:0] PART_NONE      = 4'd15;

    // Status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_TAG  = 2'd1;
    localparam logic [1:0] ST_EARLY    = 2'd2;
    localparam logic [1:0] ST_TRAILING = 2'd3;

    // Constant pool tags.
    localparam logic [7:0] TAG_UTF8    = 8'd1;
    localparam logic [7:0] TAG_INT     = 8'd3;
    localparam logic [7:0] TAG_FLOAT   = 8'd4;
    localparam logic [7:0] TAG_LONG    = 8'd5;
    localparam logic [7:0] TAG_DOUBLE  = 8'd6;
    localparam logic [7:0] TAG_FIELDREF = 8'd9;
    localparam logic [7:0] TAG_NAMETYPE = 8'd12;
    localparam logic [7:0] TAG_MHANDLE = 8'd15;
    localparam logic [7:0] TAG_MTYPE   = 8'd16;
    localparam logic [7:0] TAG_INDY    = 8'd18;

    localparam int OUT_W = 120;

    function automatic logic tag_ok(input logic [7:0] t);
        return t == TAG_UTF8 || (t >= TAG_INT && t <= TAG_NAMETYPE) ||
               t == TAG_MHANDLE || t == TAG_MTYPE || t == TAG_INDY;
    endfunction

    function automatic logic [3:0] first_len(input logic [7:0] t);
        logic [3:0] n;
        n = 4'd2;
        if (t == TAG_INT || t == TAG_FLOAT) n = 4'd4;
        else if (t == TAG_LONG || t == TAG_DOUBLE) n = 4'd8;
        else if (t == TAG_MHANDLE) n = 4'd1;
        return n;
    endfunction

    function automatic logic has_second(input logic [7:0] t);
        return (t >= TAG_FIELDREF && t <= TAG_NAMETYPE) || t == TAG_MHANDLE || t == TAG_INDY;
    endfunction

endpackage

`default_nettype wire

>>> rtl/class_file_stream_parser.sv
// Each accepted byte's result item is registered; it shows on the master side in the cycle after the byte is accepted.
// Throughput: one byte per cycle; one item is taken in every cycle while the
//   result register is empty or being drained in the same cycle.
// Reset (aresetn low, synchronous): parser returns to the magic phase with all
//   counters cleared but the pool index (set to one), status ok, and the result register empty.
`timescale 1ns / 1ps
`default_nettype none
`include "class_file_stream_parser_defines.svh"

module class_file_stream_parser
    import cfsp_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [7:0]         s_tdata,   // data_byte[7:0]
    input  wire logic               s_tlast,   // last_byte
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    // section[3:0], entry_index[19:4], attr_index[35:20], part_code[39:36],
    // const_tag[47:40], field_done[48], field_value[112:49],
    // payload_byte[113], status[115:114], zeros[119:116]
    output logic [OUT_W-1:0]        m_tdata
);

    // Parser state.
    logic [4:0]  ph_reg, ph_next;
    logic [2:0]  k_reg, k_next;
    logic [63:0] acc_reg, acc_next;
    logic [15:0] pt_reg, pt_next;      // pool count
    logic [15:0] pp_reg, pp_next;      // pool index
    logic [7:0]  tag_reg, tag_next;
    logic [15:0] lt_reg, lt_next;      // list count
    logic [15:0] lp_reg, lp_next;
    logic [15:0] at_reg, at_next;      // attribute count
    logic [15:0] ap_reg, ap_next;
    logic [31:0] pl_reg, pl_next;      // payload bytes left
    logic [1:0]  err_reg, err_next;

    // Result register.
    logic               mv_reg;
    logic [OUT_W-1:0]   md_reg;

    logic        s_acc;
    logic [3:0]  o_sec, o_part;
    logic [15:0] o_ent, o_att;
    logic [7:0]  o_tag;
    logic        o_done, o_pay;
    logic [63:0] o_val;

    logic [4:0]  base;
    logic [4:0]  sub_full;
    logic [1:0]  sub;
    logic        is_pay;
    logic [16:0] pool_nx;
    logic [15:0] lp_inc, ap_inc;
    logic [3:0]  k_plus;
    logic [4:0]  member_done_ph;

    assign s_tready = !mv_reg || m_tready;
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;

    // One byte's full step: shift the byte into the accumulator, then advance
    // the layout walk. All of it is combinational.
    always_comb begin
        ph_next  = ph_reg;
        k_next   = k_reg;
        acc_next = acc_reg;
        pt_next  = pt_reg;
        pp_next  = pp_reg;
        tag_next = tag_reg;
        lt_next  = lt_reg;
        lp_next  = lp_reg;
        at_next  = at_reg;
        ap_next  = ap_reg;
        pl_next  = pl_reg;
        err_next = err_reg;

        o_sec  = SEC_FINISHED;
        o_part = PART_NONE;
        o_ent  = 16'd0;
        o_att  = 16'd0;
        o_tag  = 8'd0;
        o_done = 1'b0;
        o_val  = 64'd0;
        o_pay  = 1'b0;

        base = (ph_reg >= PH_CBASE) ? PH_CBASE : ((ph_reg >= PH_MBASE) ? PH_MBASE : PH_FBASE);
        sub_full = ph_reg - base;
        sub      = sub_full[1:0];
        is_pay   = ph_reg == PH_UTF8 || ph_reg == PH_FBASE + 5'd3 ||
                   ph_reg == PH_MBASE + 5'd3 || ph_reg == PH_CBASE + 5'd3;
        pool_nx  = {1'b0, pp_reg} +
                   (((tag_reg == TAG_LONG) || (tag_reg == TAG_DOUBLE)) ? 17'd2 : 17'd1);
        lp_inc   = lp_reg + 16'd1;
        ap_inc   = ap_reg + 16'd1;
        k_plus   = {1'b0, k_reg} + 4'd1;
        member_done_ph = (base == PH_FBASE) ? PH_MBASE : PH_CBASE;

        // Any byte after a complete file is an error.
        if (err_reg == ST_OK && ph_reg == PH_DONE) begin
            err_next = ST_TRAILING;
        end

        if (err_next == ST_OK) begin
            if (!is_pay) begin
                acc_next = {acc_reg[55:0], s_tdata};
            end
            k_next = k_plus[2:0];

            if (ph_reg == PH_MAGIC) begin
                o_sec = SEC_MAGIC; o_part = PART_MAGIC;
                if (k_reg == 3'd3) begin
                    o_done = 1'b1; ph_next = PH_VERSION; k_next = 3'd0;
                end
            end else if (ph_reg == PH_VERSION) begin
                o_sec  = SEC_VERSION;
                o_part = (k_reg < 3'd2) ? PART_MINOR : PART_MAJOR;
                o_done = k_reg[0];
                if (k_reg == 3'd3) begin
                    ph_next = PH_PCOUNT; k_next = 3'd0;
                end
            end else if (ph_reg == PH_PCOUNT) begin
                o_sec = SEC_POOL; o_part = PART_COUNT;
                if (k_reg == 3'd1) begin
                    o_done  = 1'b1;
                    pt_next = acc_next[15:0];
                    pp_next = 16'd1;
                    ph_next = (acc_next[15:0] > 16'd1) ? PH_CPTAG : PH_HEADER;
                    k_next  = 3'd0;
                end
            end else if (ph_reg >= PH_CPTAG && ph_reg <= PH_UTF8) begin
                o_sec = SEC_POOL;
                o_ent = pp_reg;
                o_tag = tag_reg;
                if (ph_reg == PH_CPTAG) begin
                    o_part   = PART_TAG;
                    o_done   = 1'b1;
                    o_tag    = s_tdata;
                    tag_next = s_tdata;
                    if (!tag_ok(s_tdata)) begin
                        err_next = ST_BAD_TAG;
                    end else begin
                        ph_next = PH_CPA; k_next = 3'd0;
                    end
                end else if (ph_reg == PH_CPA) begin
                    o_part = PART_CONST_A;
                    if (k_plus == first_len(tag_reg)) begin
                        o_done = 1'b1;
                        k_next = 3'd0;
                        if (tag_reg == TAG_UTF8) begin
                            pl_next = {16'd0, acc_next[15:0]};
                            if (acc_next[15:0] != 16'd0) begin
                                ph_next = PH_UTF8;
                            end else if (pool_nx >= {1'b0, pt_reg}) begin
                                ph_next = PH_HEADER;
                            end else begin
                                pp_next = pool_nx[15:0]; ph_next = PH_CPTAG;
                            end
                        end else if (has_second(tag_reg)) begin
                            ph_next = PH_CPB;
                        end else if (pool_nx >= {1'b0, pt_reg}) begin
                            ph_next = PH_HEADER;
                        end else begin
                            pp_next = pool_nx[15:0]; ph_next = PH_CPTAG;
                        end
                    end
                end else if (ph_reg == PH_CPB) begin
                    o_part = PART_CONST_B;
                    if (k_reg == 3'd1) begin
                        o_done = 1'b1;
                        k_next = 3'd0;
                        if (pool_nx >= {1'b0, pt_reg}) begin
                            ph_next = PH_HEADER;
                        end else begin
                            pp_next = pool_nx[15:0]; ph_next = PH_CPTAG;
                        end
                    end
                end else begin
                    // Utf8 body
                    o_part = PART_PAYLOAD; o_pay = 1'b1;
                    if (pl_reg != 32'd0) pl_next = pl_reg - 32'd1;
                    if (pl_reg <= 32'd1) begin
                        k_next = 3'd0;
                        if (pool_nx >= {1'b0, pt_reg}) begin
                            ph_next = PH_HEADER;
                        end else begin
                            pp_next = pool_nx[15:0]; ph_next = PH_CPTAG;
                        end
                    end
                end
            end else if (ph_reg == PH_HEADER) begin
                o_sec  = SEC_HEADER;
                o_part = PART_FLAGS + {2'd0, k_reg[2:1]};
                o_done = k_reg[0];
                if (k_reg == 3'd5) begin
                    ph_next = PH_ICOUNT; k_next = 3'd0;
                end
            end else if (ph_reg == PH_ICOUNT) begin
                o_sec = SEC_IFACE; o_part = PART_COUNT;
                if (k_reg == 3'd1) begin
                    o_done  = 1'b1;
                    lt_next = acc_next[15:0];
                    lp_next = 16'd0;
                    ph_next = (acc_next[15:0] != 16'd0) ? PH_IENTRY : PH_FBASE;
                    k_next  = 3'd0;
                end
            end else if (ph_reg == PH_IENTRY) begin
                o_sec = SEC_IFACE; o_part = PART_IFACE; o_ent = lp_reg;
                if (k_reg == 3'd1) begin
                    o_done  = 1'b1;
                    lp_next = lp_inc;
                    ph_next = (lp_inc >= lt_reg) ? PH_FBASE : PH_IENTRY;
                    k_next  = 3'd0;
                end
            end else if (ph_reg < PH_DONE) begin
                // fields, methods, class attributes
                o_sec = (base == PH_FBASE) ? SEC_FIELDS :
                        ((base == PH_MBASE) ? SEC_METHODS : SEC_CATTR);
                if (base == PH_CBASE) begin
                    o_ent = ap_reg;
                end else begin
                    o_ent = lp_reg; o_att = ap_reg;
                end
                case (sub)
                    SUB_COUNT: begin
                        o_part = PART_COUNT; o_ent = 16'd0; o_att = 16'd0;
                        if (k_reg == 3'd1) begin
                            o_done = 1'b1;
                            k_next = 3'd0;
                            if (base == PH_CBASE) begin
                                at_next = acc_next[15:0];
                                ap_next = 16'd0;
                                ph_next = (acc_next[15:0] != 16'd0) ? base + 5'd2 : PH_DONE;
                            end else begin
                                lt_next = acc_next[15:0];
                                lp_next = 16'd0;
                                ph_next = (acc_next[15:0] != 16'd0) ? base + 5'd1 :
                                          member_done_ph;
                            end
                        end
                    end
                    SUB_MEMBER: begin
                        o_att  = 16'd0;
                        o_part = (k_reg < 3'd6) ? PART_FLAGS + {2'd0, k_reg[2:1]} :
                                 PART_ATTR_CNT;
                        o_done = k_reg[0];
                        if (k_reg == 3'd7) begin
                            at_next = acc_next[15:0];
                            ap_next = 16'd0;
                            k_next  = 3'd0;
                            if (acc_next[15:0] != 16'd0) begin
                                ph_next = base + 5'd2;
                            end else begin
                                lp_next = lp_inc;
                                ph_next = (lp_inc >= lt_reg) ? member_done_ph : base + 5'd1;
                            end
                        end
                    end
                    SUB_ATTR: begin
                        o_part = (k_reg < 3'd2) ? PART_ATTR_NAME : PART_ATTR_LEN;
                        o_done = (k_reg == 3'd1) || (k_reg == 3'd5);
                        if (k_reg == 3'd5) begin
                            pl_next = acc_next[31:0];
                            k_next  = 3'd0;
                            if (acc_next[31:0] != 32'd0) begin
                                ph_next = base + 5'd3;
                            end else begin
                                ap_next = ap_inc;
                                if (ap_inc < at_reg) begin
                                    ph_next = base + 5'd2;
                                end else if (base == PH_CBASE) begin
                                    ph_next = PH_DONE;
                                end else begin
                                    lp_next = lp_inc;
                                    ph_next = (lp_inc >= lt_reg) ? member_done_ph :
                                              base + 5'd1;
                                end
                            end
                        end
                    end
                    default: begin
                        // attribute body
                        o_part = PART_PAYLOAD; o_pay = 1'b1;
                        if (pl_reg != 32'd0) pl_next = pl_reg - 32'd1;
                        if (pl_reg <= 32'd1) begin
                            k_next  = 3'd0;
                            ap_next = ap_inc;
                            if (ap_inc < at_reg) begin
                                ph_next = base + 5'd2;
                            end else if (base == PH_CBASE) begin
                                ph_next = PH_DONE;
                            end else begin
                                lp_next = lp_inc;
                                ph_next = (lp_inc >= lt_reg) ? member_done_ph :
                                          base + 5'd1;
                            end
                        end
                    end
                endcase
            end

            if (o_done) begin
                o_val    = acc_next;
                acc_next = 64'd0;
            end
            if (s_tlast && ph_next != PH_DONE && err_next == ST_OK) begin
                err_next = ST_EARLY;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg  <= PH_MAGIC;
            k_reg   <= 3'd0;
            acc_reg <= 64'd0;
            pt_reg  <= 16'd0;
            pp_reg  <= 16'd1;
            tag_reg <= 8'd0;
            lt_reg  <= 16'd0;
            lp_reg  <= 16'd0;
            at_reg  <= 16'd0;
            ap_reg  <= 16'd0;
            pl_reg  <= 32'd0;
            err_reg <= ST_OK;
            mv_reg  <= 1'b0;
        end else begin
            if (s_acc) begin
                ph_reg  <= ph_next;
                k_reg   <= k_next;
                acc_reg <= acc_next;
                pt_reg  <= pt_next;
                pp_reg  <= pp_next;
                tag_reg <= tag_next;
                lt_reg  <= lt_next;
                lp_reg  <= lp_next;
                at_reg  <= at_next;
                ap_reg  <= ap_next;
                pl_reg  <= pl_next;
                err_reg <= err_next;
                mv_reg  <= 1'b1;
            end else if (m_tready) begin
                mv_reg  <= 1'b0;
            end
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            md_reg <= {4'd0, err_next, o_pay, o_val, o_done, o_tag, o_part,
                       o_att, o_ent, o_sec};
        end
    end

    // Errors are sticky.
    `CFSP_ASSERT_NEXT(a_err_sticky, err_reg != ST_OK, err_reg == $past(err_reg))
    // An accepted byte always leaves a result behind.
    `CFSP_ASSERT_NEXT(a_acc_result, s_acc, mv_reg)
    // A numeric field and a payload byte never coincide.
    `CFSP_ASSERT_NOW(a_done_vs_pay, mv_reg, !(md_reg[48] && md_reg[113]))
    // A nonzero status reports the finished section, unless it flags a bad tag or an early end.
    `CFSP_ASSERT_NOW(a_err_sec, mv_reg && md_reg[115:114] != ST_OK,
                     md_reg[3:0] == SEC_FINISHED || md_reg[39:36] == PART_TAG ||
                     md_reg[115:114] == ST_EARLY)

endmodule

`default_nettype wire

>>> tb/tb_class_file_stream_parser.sv
`timescale 1ns / 1ps

module tb_class_file_stream_parser;
    import cfsp_pkg::*;

    // Tags with no name in the package.
    localparam logic [7:0] TAG_CLASS      = 8'd7;
    localparam logic [7:0] TAG_STRING     = 8'd8;
    localparam logic [7:0] TAG_METHODREF  = 8'd10;
    localparam logic [7:0] TAG_IMETHODREF = 8'd11;

    // How the file is ended.
    localparam int END_TRAILING = 0;
    localparam int END_BAD_TAG  = 1;
    localparam int END_EARLY    = 2;

    localparam int STALL_LIMIT = 2000;
    localparam int N_ITEMS     = 1350;

    typedef struct packed {
        logic [3:0]  sec;
        logic [15:0] ent;
        logic [15:0] att;
        logic [3:0]  part;
        logic [7:0]  tag;
        logic        done;
        logic [63:0] val;
        logic        pay;
        logic [1:0]  st;
    } token_t;

    typedef struct {
        logic [7:0] d;
        logic       l;
        bit         typed;    // expectation written into the row
        token_t     e;
    } byte_row_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata = 8'd0;   // data_byte[7:0]
    logic             s_tlast = 1'b0;   // last_byte
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;          // section .. status, see the block's port list

    class_file_stream_parser u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Parser shadow state
    // ------------------------------------------------------------------
    logic [4:0]  phase;
    logic [2:0]  fld_byte;
    logic [63:0] acc;
    logic [15:0] pool_cnt, pool_pos;
    logic [7:0]  cur_tag;
    logic [15:0] list_cnt, list_pos;
    logic [15:0] attr_cnt, attr_pos;
    logic [31:0] body_left;
    logic [1:0]  err;

    byte_row_t file_bytes[$];   // the whole stream, built up front
    token_t    pending_tokens[$];
    int        send_pos = 0;
    int        errors = 0;
    int        cyc = 0;
    int        stall = 0;
    int        tag_spots[$];    // positions of pool tag bytes

    task automatic clear_parser();
        phase = PH_MAGIC; fld_byte = 0; acc = 0;
        pool_cnt = 0; pool_pos = 1; cur_tag = 0;
        list_cnt = 0; list_pos = 0; attr_cnt = 0; attr_pos = 0;
        body_left = 0; err = ST_OK;
    endtask

    function automatic bit known_tag(input logic [7:0] t);
        case (t)
            TAG_UTF8, TAG_INT, TAG_FLOAT, TAG_LONG, TAG_DOUBLE, TAG_CLASS, TAG_STRING,
            TAG_FIELDREF, TAG_METHODREF, TAG_IMETHODREF, TAG_NAMETYPE, TAG_MHANDLE,
            TAG_MTYPE, TAG_INDY: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // Byte count of the first item of a constant.
    function automatic int item_a_len(input logic [7:0] t);
        case (t)
            TAG_INT, TAG_FLOAT: return 4;
            TAG_LONG, TAG_DOUBLE: return 8;
            TAG_MHANDLE: return 1;
            default: return 2;
        endcase
    endfunction

    function automatic bit has_item_b(input logic [7:0] t);
        case (t)
            TAG_FIELDREF, TAG_METHODREF, TAG_IMETHODREF, TAG_NAMETYPE,
            TAG_MHANDLE, TAG_INDY: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    task automatic jump(input logic [4:0] p);
        phase = p;
        fld_byte = 0;
    endtask

    task automatic advance_pool();
        logic [16:0] nx;
        nx = {1'b0, pool_pos} +
             ((cur_tag == TAG_LONG || cur_tag == TAG_DOUBLE) ? 17'd2 : 17'd1);
        if (nx >= {1'b0, pool_cnt}) begin
            jump(PH_HEADER);
        end else begin
            pool_pos = nx[15:0];
            jump(PH_CPTAG);
        end
    endtask

    task automatic close_member(input logic [4:0] base);
        list_pos++;
        if (list_pos >= list_cnt) jump(base == PH_FBASE ? PH_MBASE : PH_CBASE);
        else jump(base + 5'd1);
    endtask

    task automatic close_attr(input logic [4:0] base);
        attr_pos++;
        if (attr_pos >= attr_cnt) begin
            if (base == PH_CBASE) jump(PH_DONE);
            else close_member(base);
        end else begin
            jump(base + 5'd2);
        end
    endtask

    // Token for one byte; advances the shadow state.
    task automatic parse_byte(input logic [7:0] b, input logic last, output token_t r);
        logic [4:0] ph, base, sub;
        logic [2:0] k;
        r = '0;
        r.sec = SEC_FINISHED;
        r.part = PART_NONE;
        ph = phase;
        k = fld_byte;
        if (err == ST_OK && ph == PH_DONE) err = ST_TRAILING;
        if (err == ST_OK) begin
            if (!(ph == PH_UTF8 || ph == PH_FBASE + 5'd3 || ph == PH_MBASE + 5'd3 ||
                  ph == PH_CBASE + 5'd3))
                acc = {acc[55:0], b};
            fld_byte = k + 3'd1;
            if (ph == PH_MAGIC) begin
                r.sec = SEC_MAGIC; r.part = PART_MAGIC;
                if (k == 3'd3) begin
                    r.done = 1'b1; jump(PH_VERSION);
                end
            end else if (ph == PH_VERSION) begin
                r.sec = SEC_VERSION;
                r.part = k < 3'd2 ? PART_MINOR : PART_MAJOR;
                r.done = k[0];
                if (k == 3'd3) jump(PH_PCOUNT);
            end else if (ph == PH_PCOUNT) begin
                r.sec = SEC_POOL; r.part = PART_COUNT;
                if (k == 3'd1) begin
                    r.done = 1'b1;
                    pool_cnt = acc[15:0];
                    pool_pos = 16'd1;
                    jump(pool_cnt > 16'd1 ? PH_CPTAG : PH_HEADER);
                end
            end else if (ph >= PH_CPTAG && ph <= PH_UTF8) begin
                r.sec = SEC_POOL; r.ent = pool_pos;
                if (ph == PH_CPTAG) begin
                    r.part = PART_TAG; r.done = 1'b1;
                    cur_tag = b;
                    if (!known_tag(b)) err = ST_BAD_TAG;
                    else jump(PH_CPA);
                end else if (ph == PH_CPA) begin
                    r.part = PART_CONST_A;
                    if (int'(k) + 1 == item_a_len(cur_tag)) begin
                        r.done = 1'b1;
                        if (cur_tag == TAG_UTF8) begin
                            body_left = {16'd0, acc[15:0]};
                            if (body_left == 0) advance_pool(); else jump(PH_UTF8);
                        end else if (has_item_b(cur_tag)) begin
                            jump(PH_CPB);
                        end else begin
                            advance_pool();
                        end
                    end
                end else if (ph == PH_CPB) begin
                    r.part = PART_CONST_B;
                    if (k == 3'd1) begin
                        r.done = 1'b1; advance_pool();
                    end
                end else begin
                    r.part = PART_PAYLOAD; r.pay = 1'b1;
                    if (body_left > 0) body_left--;
                    if (body_left == 0) advance_pool();
                end
                r.tag = cur_tag;
            end else if (ph == PH_HEADER) begin
                r.sec = SEC_HEADER;
                r.part = PART_FLAGS + {2'd0, k[2:1]};
                r.done = k[0];
                if (k == 3'd5) jump(PH_ICOUNT);
            end else if (ph == PH_ICOUNT) begin
                r.sec = SEC_IFACE; r.part = PART_COUNT;
                if (k == 3'd1) begin
                    r.done = 1'b1;
                    list_cnt = acc[15:0];
                    list_pos = 16'd0;
                    jump(list_cnt != 0 ? PH_IENTRY : PH_FBASE);
                end
            end else if (ph == PH_IENTRY) begin
                r.sec = SEC_IFACE; r.part = PART_IFACE; r.ent = list_pos;
                if (k == 3'd1) begin
                    r.done = 1'b1;
                    list_pos++;
                    jump(list_pos >= list_cnt ? PH_FBASE : PH_IENTRY);
                end
            end else if (ph >= PH_FBASE && ph < PH_DONE) begin
                base = ph >= PH_CBASE ? PH_CBASE : (ph >= PH_MBASE ? PH_MBASE : PH_FBASE);
                sub = ph - base;
                r.sec = base == PH_FBASE ? SEC_FIELDS :
                        (base == PH_MBASE ? SEC_METHODS : SEC_CATTR);
                if (base == PH_CBASE) begin
                    r.ent = attr_pos; r.att = 16'd0;
                end else begin
                    r.ent = list_pos; r.att = attr_pos;
                end
                if (sub == {3'd0, SUB_COUNT}) begin
                    r.part = PART_COUNT; r.ent = 16'd0; r.att = 16'd0;
                    if (k == 3'd1) begin
                        r.done = 1'b1;
                        if (base == PH_CBASE) begin
                            attr_cnt = acc[15:0];
                            attr_pos = 16'd0;
                            jump(attr_cnt != 0 ? base + 5'd2 : PH_DONE);
                        end else begin
                            list_cnt = acc[15:0];
                            list_pos = 16'd0;
                            if (list_cnt != 0) jump(base + 5'd1);
                            else jump(base == PH_FBASE ? PH_MBASE : PH_CBASE);
                        end
                    end
                end else if (sub == {3'd0, SUB_MEMBER}) begin
                    r.att = 16'd0;
                    r.part = k < 3'd6 ? PART_FLAGS + {2'd0, k[2:1]} : PART_ATTR_CNT;
                    r.done = k[0];
                    if (k == 3'd7) begin
                        attr_cnt = acc[15:0];
                        attr_pos = 16'd0;
                        if (attr_cnt != 0) jump(base + 5'd2); else close_member(base);
                    end
                end else if (sub == {3'd0, SUB_ATTR}) begin
                    r.part = k < 3'd2 ? PART_ATTR_NAME : PART_ATTR_LEN;
                    r.done = (k == 3'd1 || k == 3'd5);
                    if (k == 3'd5) begin
                        body_left = acc[31:0];
                        if (body_left == 0) close_attr(base); else jump(base + 5'd3);
                    end
                end else begin
                    r.part = PART_PAYLOAD; r.pay = 1'b1;
                    if (body_left > 0) body_left--;
                    if (body_left == 0) close_attr(base);
                end
            end
            if (r.done) begin
                r.val = acc;
                acc = 64'd0;
            end
            if (last && phase != PH_DONE && err == ST_OK) err = ST_EARLY;
        end
        r.st = err;
    endtask

    // ------------------------------------------------------------------
    // File builder
    // ------------------------------------------------------------------
    function automatic token_t tok(input logic [3:0] sec, input logic [3:0] part,
                                   input logic done, input logic [63:0] val);
        token_t t;
        t = '0;
        t.sec = sec; t.part = part; t.done = done; t.val = val;
        return t;
    endfunction

    task automatic put_typed(input logic [7:0] d, input token_t e);
        file_bytes.push_back('{d: d, l: 1'b0, typed: 1'b1, e: e});
    endtask

    // Big-endian field of n bytes.
    task automatic put_field(input logic [63:0] v, input int n);
        for (int i = n - 1; i >= 0; i--)
            file_bytes.push_back('{d: v[8*i +: 8], l: 1'b0, typed: 1'b0, e: '0});
    endtask

    function automatic int pick_count(input int hi);
        return ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, hi);
    endfunction

    task automatic put_attrs(input int n);
        int len;
        for (int i = 0; i < n; i++) begin
            len = pick_count(8);
            put_field(64'($urandom), 2);
            put_field(64'(len), 4);
            for (int j = 0; j < len; j++) put_field(64'($urandom), 1);
        end
    endtask

    task automatic put_members(input int n);
        int a;
        put_field(64'(n), 2);
        for (int i = 0; i < n; i++) begin
            a = pick_count(3);
            put_field({$urandom, $urandom}, 6);
            put_field(64'(a), 2);
            put_attrs(a);
        end
    endtask

    task automatic build_file();
        logic [7:0] all_tags[14];
        logic [7:0] t;
        int count, slot, n, len, how, cut;
        all_tags = '{TAG_UTF8, TAG_INT, TAG_FLOAT, TAG_LONG, TAG_DOUBLE, TAG_CLASS,
                     TAG_STRING, TAG_FIELDREF, TAG_METHODREF, TAG_IMETHODREF,
                     TAG_NAMETYPE, TAG_MHANDLE, TAG_MTYPE, TAG_INDY};
        // Directed head: magic, minor at its top, major at zero.
        put_typed(8'hCA, tok(SEC_MAGIC, PART_MAGIC, 1'b0, 64'd0));
        put_typed(8'hFE, tok(SEC_MAGIC, PART_MAGIC, 1'b0, 64'd0));
        put_typed(8'hBA, tok(SEC_MAGIC, PART_MAGIC, 1'b0, 64'd0));
        put_typed(8'hBE, tok(SEC_MAGIC, PART_MAGIC, 1'b1, 64'hCAFEBABE));
        put_typed(8'hFF, tok(SEC_VERSION, PART_MINOR, 1'b0, 64'd0));
        put_typed(8'hFF, tok(SEC_VERSION, PART_MINOR, 1'b1, 64'hFFFF));
        put_typed(8'h00, tok(SEC_VERSION, PART_MAJOR, 1'b0, 64'd0));
        put_typed(8'h00, tok(SEC_VERSION, PART_MAJOR, 1'b1, 64'h0));

        // Pool: every tag once first, then random; now and then no entries at all.
        count = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(100, 180);
        put_field(64'(count), 2);
        slot = 1;
        n = 0;
        while (slot < count) begin
            if (n < 14) t = all_tags[n];
            else if (slot == count - 1 && $urandom_range(0, 1) == 1) t = TAG_LONG;
            else t = all_tags[$urandom_range(0, 13)];
            n++;
            tag_spots.push_back(file_bytes.size());
            put_field({56'd0, t}, 1);
            if (t == TAG_UTF8) begin
                len = pick_count(10);
                put_field(64'(len), 2);
                for (int j = 0; j < len; j++) put_field(64'($urandom), 1);
            end else begin
                put_field({$urandom, $urandom}, item_a_len(t));
            end
            if (has_item_b(t)) put_field(64'($urandom), 2);
            slot += (t == TAG_LONG || t == TAG_DOUBLE) ? 2 : 1;
        end

        put_field({$urandom, $urandom}, 6);   // flags, this, super
        n = pick_count(6);
        put_field(64'(n), 2);
        for (int i = 0; i < n; i++) put_field(64'($urandom), 2);
        put_members(pick_count(6));           // fields
        put_members(pick_count(6));           // methods
        n = pick_count(3);
        put_field(64'(n), 2);
        put_attrs(n);

        // The whole run is one file, so exactly one way of ending it.
        how = $urandom_range(0, 2);
        if (how == END_BAD_TAG && tag_spots.size() == 0) how = END_TRAILING;
        if (how == END_BAD_TAG) begin
            cut = tag_spots[$urandom_range(0, tag_spots.size() - 1)];
            do t = 8'($urandom); while (known_tag(t));
            file_bytes[cut].d = t;
            while (file_bytes.size() > cut + 1) void'(file_bytes.pop_back());
        end else if (how == END_EARLY) begin
            // Past the typed head, whose rows expect status ok.
            cut = $urandom_range(8, file_bytes.size() - 2);
            while (file_bytes.size() > cut + 1) void'(file_bytes.pop_back());
            file_bytes[cut].l = 1'b1;
        end else begin
            file_bytes[file_bytes.size() - 1].l = 1'b1;
        end
        // Bytes after the file ended or froze, filling the run up to its item count.
        for (int i = 0; i < 4 || file_bytes.size() < N_ITEMS; i++) begin
            put_field(64'($urandom), 1);
            file_bytes[file_bytes.size() - 1].l = 1'($urandom_range(0, 1));
        end
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        errors++;
        $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    endtask

    task automatic compare_token(input token_t g, input token_t e);
        if (g.sec  !== e.sec)  report("section", 64'(g.sec), 64'(e.sec));
        if (g.ent  !== e.ent)  report("entry_index", 64'(g.ent), 64'(e.ent));
        if (g.att  !== e.att)  report("attr_index", 64'(g.att), 64'(e.att));
        if (g.part !== e.part) report("part_code", 64'(g.part), 64'(e.part));
        if (g.tag  !== e.tag)  report("const_tag", 64'(g.tag), 64'(e.tag));
        if (g.done !== e.done) report("field_done", 64'(g.done), 64'(e.done));
        if (g.val  !== e.val)  report("field_value", g.val, e.val);
        if (g.pay  !== e.pay)  report("payload_byte", 64'(g.pay), 64'(e.pay));
        if (g.st   !== e.st)   report("status", 64'(g.st), 64'(e.st));
    endtask

    // Driving, prediction at the input handshake, checking at the output handshake.
    always @(posedge aclk) begin
        token_t got, want;
        bit quiet, moved;
        if (aresetn) begin
            cyc++;
            moved = 0;
            if (s_tvalid && s_tready) begin
                moved = 1;
                parse_byte(s_tdata, s_tlast, want);
                // Rows with a typed expectation still advance the shadow state.
                if (file_bytes[send_pos].typed) want = file_bytes[send_pos].e;
                pending_tokens.push_back(want);
                send_pos++;
            end
            if (m_tvalid && m_tready) begin
                moved = 1;
                got.sec  = m_tdata[3:0];
                got.ent  = m_tdata[19:4];
                got.att  = m_tdata[35:20];
                got.part = m_tdata[39:36];
                got.tag  = m_tdata[47:40];
                got.done = m_tdata[48];
                got.val  = m_tdata[112:49];
                got.pay  = m_tdata[113];
                got.st   = m_tdata[115:114];
                if (pending_tokens.size() == 0) begin
                    report("unexpected result item", m_tdata[63:0], 64'd0);
                end else begin
                    compare_token(got, pending_tokens.pop_front());
                end
            end

            // A long stretch with neither side idling.
            quiet = cyc >= 300 && cyc < 700;
            if (!(s_tvalid && !s_tready)) begin
                if (send_pos < file_bytes.size() &&
                    (quiet || $urandom_range(0, 99) >= 24)) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= file_bytes[send_pos].d;
                    s_tlast  <= file_bytes[send_pos].l;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= quiet || $urandom_range(0, 99) >= 24;

            stall = moved ? 0 : stall + 1;
            if (stall >= STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        clear_parser();
        build_file();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        while (send_pos < file_bytes.size()) @(posedge aclk);
        while (pending_tokens.size() != 0) @(posedge aclk);
        repeat (5) @(posedge aclk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
